>>> hw/rtl/ilie_pkg.sv
// Package for the indexed list block: request codes, controller states and
// the command word that the controller broadcasts to the row of entry cells.
// No dependencies.
package ilie_pkg;

	// Width of a position or a count inside the row; holds up to 2047.
	localparam int POS_W = 11;
	localparam int DATA_W = 32;

	// Request codes on the op port.
	typedef enum logic [3:0] {
		OP_READ   = 4'd0,
		OP_WRITE  = 4'd1,
		OP_INSERT = 4'd2,
		OP_ERASE  = 4'd3,
		OP_PUSH   = 4'd4,
		OP_POP    = 4'd5,
		OP_CLEAR  = 4'd6,
		OP_RESIZE = 4'd7,
		OP_ASSIGN = 4'd8
	} ilie_op_t;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} ilie_state_t;

	// What each cell does with its entry in the execute cycle.
	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_FILL,
		CMD_SHIFT_UP,
		CMD_SHIFT_DOWN
	} ilie_cmd_kind_t;

	// Command word seen by every cell; lo and hi bound the affected span.
	typedef struct packed {
		ilie_cmd_kind_t      kind;
		logic                rd;
		logic [POS_W-1:0]    lo;
		logic [POS_W-1:0]    hi;
		logic [DATA_W-1:0]   value;
	} ilie_cmd_t;

endpackage

>>> hw/rtl/ilie_cell.sv
// One entry cell of the list row: holds one entry and takes the value, its
// lower neighbor's entry or its upper neighbor's entry on command.
// Depends on ilie_pkg.
module ilie_cell #(
	parameter int POS = 0
) (
	input  logic                             clk,
	input  ilie_pkg::ilie_cmd_t              cmd,
	input  logic [ilie_pkg::DATA_W-1:0]      left,
	input  logic [ilie_pkg::DATA_W-1:0]      right,
	output logic [ilie_pkg::DATA_W-1:0]      entry,
	output logic [ilie_pkg::DATA_W-1:0]      rd_data
);

	localparam logic [ilie_pkg::POS_W-1:0] P = ilie_pkg::POS_W'(POS);

	logic [ilie_pkg::DATA_W-1:0] entry_q;
	logic [ilie_pkg::DATA_W-1:0] entry_d;
	logic                        we;
	logic                        at_lo;
	logic                        in_span;

	assign at_lo   = (P == cmd.lo);
	assign in_span = (P >= cmd.lo) && (P < cmd.hi);

	// Pick the new entry for this position.
	always_comb begin
		we      = 1'b0;
		entry_d = cmd.value;
		case (cmd.kind)
			ilie_pkg::CMD_FILL: begin
				we = in_span;
			end
			ilie_pkg::CMD_SHIFT_UP: begin
				if (at_lo) begin
					we = 1'b1;
				end else if (in_span) begin
					we      = 1'b1;
					entry_d = left;
				end
			end
			ilie_pkg::CMD_SHIFT_DOWN: begin
				we      = in_span;
				entry_d = right;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// Entry storage; undefined until first written.
	always_ff @(posedge clk) begin
		if (we) begin
			entry_q <= entry_d;
		end
	end

	assign entry   = entry_q;
	// Only the addressed cell drives a nonzero word into the read tree.
	assign rd_data = (cmd.rd && at_lo) ? entry_q : '0;

endmodule

>>> hw/rtl/ilie_rdtree.sv
// Registered OR tree that gathers the one nonzero read word from the row.
// Groups of eight are ORed and registered, the group words ORed after.
// Depends on ilie_pkg.
module ilie_rdtree #(
	parameter int N = 64
) (
	input  logic                             clk,
	input  logic [ilie_pkg::DATA_W-1:0]      leaf [N],
	output logic [ilie_pkg::DATA_W-1:0]      word
);

	localparam int GRP = 8;
	localparam int NG = (N + GRP - 1) / GRP;

	logic [ilie_pkg::DATA_W-1:0] grp_d [NG];
	logic [ilie_pkg::DATA_W-1:0] grp_s1 [NG];

	// First level: OR each group of leaves.
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < N) begin
					grp_d[g] = grp_d[g] | leaf[g * GRP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	// Second level: OR the registered group words.
	always_comb begin
		word = '0;
		for (int g = 0; g < NG; g++) begin
			word = word | grp_s1[g];
		end
	end

endmodule

>>> hw/rtl/indexed_list_insert_erase.sv
// Top level of the indexed list: request decoder, count register, row of
// entry cells and the read tree. Depends on ilie_pkg, ilie_cell, ilie_rdtree.
//
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+------------------------
//  request   | op, index, value, length            | start high, busy low
//  result    | read_value, count_now, status       | done, one cycle, no stall
//
// Every request passes through an execute cycle in which all cells shift or
// fill their entries in parallel and the first level of the read tree
// registers, then the result cycle that carries the second level. busy is
// high in both, so the next word is taken in the cycle after the result cycle
// at the earliest: a new request is not taken while one is still in flight.
// The receiver cannot stall done. Reset clears the count, the status and the controller;
// entries are not cleared and are only read below the count.
module indexed_list_insert_erase #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  op,
	input  logic [5:0]  index,
	input  logic [31:0] value,
	input  logic [6:0]  length,
	output logic        done,
	output logic [31:0] read_value,
	output logic [6:0]  count_now,
	output logic [1:0]  status
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int W = ilie_pkg::POS_W;
	localparam logic [W-1:0] CAP_W = W'(CAPACITY);

	ilie_pkg::ilie_state_t state_q, state_d;

	logic [3:0]               op_q;
	logic [5:0]               index_q;
	logic [31:0]              value_q;
	logic [6:0]               length_q;
	logic [CNT_W-1:0]         count_q;
	logic [1:0]               status_q;

	ilie_pkg::ilie_cmd_t      cmd;
	logic [W-1:0]             cnt_nx;
	logic [1:0]               st_nx;
	logic [W-1:0]             idx_w, cnt_w, len_w;
	logic                     accept;

	logic [ilie_pkg::DATA_W-1:0] entry_w [CAPACITY];
	logic [ilie_pkg::DATA_W-1:0] rd_w [CAPACITY];

	assign accept = start && (state_q == ilie_pkg::S_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ilie_pkg::S_IDLE: if (start) state_d = ilie_pkg::S_EXEC;
			ilie_pkg::S_EXEC: state_d = ilie_pkg::S_RESP;
			ilie_pkg::S_RESP: state_d = ilie_pkg::S_IDLE;
			default:          state_d = ilie_pkg::S_IDLE;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		busy = (state_q != ilie_pkg::S_IDLE);
		done = (state_q == ilie_pkg::S_RESP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ilie_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Request word register.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			index_q  <= index;
			value_q  <= value;
			length_q <= length;
		end
	end

	assign idx_w = W'(index_q);
	assign cnt_w = W'(count_q);
	assign len_w = W'(length_q);

	// Decode the request against the count into a cell command and status.
	always_comb begin
		cmd.kind  = ilie_pkg::CMD_NONE;
		cmd.rd    = 1'b0;
		cmd.lo    = idx_w;
		cmd.hi    = idx_w + W'(1);
		cmd.value = value_q;
		cnt_nx    = cnt_w;
		st_nx     = ilie_pkg::ST_OK;
		if (state_q == ilie_pkg::S_EXEC) begin
			case (op_q)
				ilie_pkg::OP_READ: begin
					if (idx_w >= cnt_w) st_nx = ilie_pkg::ST_RANGE;
					else cmd.rd = 1'b1;
				end
				ilie_pkg::OP_WRITE: begin
					if (idx_w >= cnt_w) st_nx = ilie_pkg::ST_RANGE;
					else cmd.kind = ilie_pkg::CMD_FILL;
				end
				ilie_pkg::OP_INSERT: begin
					if (idx_w > cnt_w) begin
						st_nx = ilie_pkg::ST_RANGE;
					end else if (cnt_w >= CAP_W) begin
						st_nx = ilie_pkg::ST_FULL;
					end else begin
						cmd.kind = ilie_pkg::CMD_SHIFT_UP;
						cmd.hi   = cnt_w + W'(1);
						cnt_nx   = cnt_w + W'(1);
					end
				end
				ilie_pkg::OP_ERASE: begin
					if (idx_w >= cnt_w) begin
						st_nx = ilie_pkg::ST_RANGE;
					end else begin
						cmd.kind = ilie_pkg::CMD_SHIFT_DOWN;
						cmd.hi   = cnt_w - W'(1);
						cnt_nx   = cnt_w - W'(1);
					end
				end
				ilie_pkg::OP_PUSH: begin
					if (cnt_w >= CAP_W) begin
						st_nx = ilie_pkg::ST_FULL;
					end else begin
						cmd.kind = ilie_pkg::CMD_FILL;
						cmd.lo   = cnt_w;
						cmd.hi   = cnt_w + W'(1);
						cnt_nx   = cnt_w + W'(1);
					end
				end
				ilie_pkg::OP_POP: begin
					if (cnt_w != '0) cnt_nx = cnt_w - W'(1);
				end
				ilie_pkg::OP_CLEAR: begin
					cnt_nx = '0;
				end
				ilie_pkg::OP_RESIZE: begin
					if (len_w > CAP_W) begin
						st_nx = ilie_pkg::ST_FULL;
					end else begin
						cmd.kind = ilie_pkg::CMD_FILL;
						cmd.lo   = cnt_w;
						cmd.hi   = len_w;
						cnt_nx   = len_w;
					end
				end
				ilie_pkg::OP_ASSIGN: begin
					if (len_w > CAP_W) begin
						st_nx = ilie_pkg::ST_FULL;
					end else begin
						cmd.kind = ilie_pkg::CMD_FILL;
						cmd.lo   = '0;
						cmd.hi   = len_w;
						cnt_nx   = len_w;
					end
				end
				default: begin
					st_nx = ilie_pkg::ST_OK;
				end
			endcase
		end
	end

	// Count and status registers, updated in the execute cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= ilie_pkg::ST_OK;
		end else if (state_q == ilie_pkg::S_EXEC) begin
			count_q  <= cnt_nx[CNT_W-1:0];
			status_q <= st_nx;
		end
	end

	// Row of entry cells, each linked to both neighbors.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ilie_pkg::DATA_W-1:0] left_w, right_w;
		if (i == 0) begin : g_lo_end
			assign left_w = '0;
		end else begin : g_lo_mid
			assign left_w = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi_end
			assign right_w = '0;
		end else begin : g_hi_mid
			assign right_w = entry_w[i+1];
		end
		ilie_cell #(
			.POS(i)
		) u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.left    (left_w),
			.right   (right_w),
			.entry   (entry_w[i]),
			.rd_data (rd_w[i])
		);
	end

	// Read gather; its second level lands in the result cycle.
	ilie_rdtree #(
		.N(CAPACITY)
	) u_rdtree (
		.clk  (clk),
		.leaf (rd_w),
		.word (read_value)
	);

	// Count reports its low seven bits.
	logic [CNT_W+6:0] count_ext;
	assign count_ext = (CNT_W + 7)'(count_q);
	assign count_now = count_ext[6:0];
	assign status    = status_q;

endmodule

>>> dv/tb.sv
// Self-checking testbench for indexed_list_insert_erase: a directed table, then
// random request words checked against a behavioral list model.
// Depends on ilie_pkg and the indexed_list_insert_erase RTL.
module tb;

	localparam int LIST_CAP = 64;
	localparam int RANDOM_WORDS = 1400;
	localparam int RING_DEPTH = 16;
	localparam int ROW_DEPTH = 32;
	localparam logic [3:0] OP_UNKNOWN = 4'd15;

	// One expected result word.
	typedef struct packed {
		logic [31:0] rd;
		logic [6:0]  cnt;
		logic [1:0]  st;
	} list_result_t;

	// One row of the directed table; pinned rows carry a typed-in result.
	typedef struct packed {
		logic [3:0]   op;
		logic [5:0]   idx;
		logic [31:0]  val;
		logic [6:0]   len;
		logic         pinned;
		list_result_t res;
	} list_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  op;
	logic [5:0]  index;
	logic [31:0] value;
	logic [6:0]  length;
	logic        done;
	logic [31:0] read_value;
	logic [6:0]  count_now;
	logic [1:0]  status;

	// Behavioral copy of the list contents and the entry count.
	logic [31:0] list_mem [LIST_CAP];
	int          list_len;

	// Expected words in flight, oldest at the head.
	list_result_t exp_ring [RING_DEPTH];
	int           exp_head;
	int           exp_tail;
	list_row_t    directed_rows [ROW_DEPTH];
	int           row_count;
	logic         row_pinned;
	list_result_t row_result;
	list_result_t model_out;
	list_result_t oldest;
	int           mismatches;

	indexed_list_insert_erase #(.CAPACITY(LIST_CAP)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.index(index),
		.value(value),
		.length(length),
		.done(done),
		.read_value(read_value),
		.count_now(count_now),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("indexed_list_insert_erase: mismatch");
		$finish;
	end

	// Apply one request to the list model and return the result it yields.
	function automatic list_result_t apply_request(input logic [3:0] rq_op,
			input logic [5:0] rq_idx, input logic [31:0] rq_val, input logic [6:0] rq_len);
		list_result_t r;
		int i;
		int idx;
		int len;
		r = '0;
		r.st = ilie_pkg::ST_OK;
		idx = int'(rq_idx);
		len = int'(rq_len);
		case (rq_op)
			ilie_pkg::OP_READ: begin
				if (idx >= list_len) r.st = ilie_pkg::ST_RANGE;
				else r.rd = list_mem[idx];
			end
			ilie_pkg::OP_WRITE: begin
				if (idx >= list_len) r.st = ilie_pkg::ST_RANGE;
				else list_mem[idx] = rq_val;
			end
			ilie_pkg::OP_INSERT: begin
				if (idx > list_len) begin
					r.st = ilie_pkg::ST_RANGE;
				end else if (list_len >= LIST_CAP) begin
					r.st = ilie_pkg::ST_FULL;
				end else begin
					for (i = list_len; i > idx; i--) list_mem[i] = list_mem[i - 1];
					list_mem[idx] = rq_val;
					list_len++;
				end
			end
			ilie_pkg::OP_ERASE: begin
				if (idx >= list_len) begin
					r.st = ilie_pkg::ST_RANGE;
				end else begin
					for (i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
					list_len--;
				end
			end
			ilie_pkg::OP_PUSH: begin
				if (list_len >= LIST_CAP) begin
					r.st = ilie_pkg::ST_FULL;
				end else begin
					list_mem[list_len] = rq_val;
					list_len++;
				end
			end
			ilie_pkg::OP_POP: begin
				if (list_len != 0) list_len--;
			end
			ilie_pkg::OP_CLEAR: begin
				list_len = 0;
			end
			ilie_pkg::OP_RESIZE: begin
				if (len > LIST_CAP) begin
					r.st = ilie_pkg::ST_FULL;
				end else begin
					for (i = list_len; i < len; i++) list_mem[i] = rq_val;
					list_len = len;
				end
			end
			ilie_pkg::OP_ASSIGN: begin
				if (len > LIST_CAP) begin
					r.st = ilie_pkg::ST_FULL;
				end else begin
					for (i = 0; i < len; i++) list_mem[i] = rq_val;
					list_len = len;
				end
			end
			default: ;
		endcase
		r.cnt = list_len[6:0];
		return r;
	endfunction

	// Check the result word first, then record the request taken at this edge.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (exp_head == exp_tail) begin
				$error("result word with no request outstanding");
				mismatches++;
			end else begin
				oldest = exp_ring[exp_head % RING_DEPTH];
				exp_head++;
				if (read_value !== oldest.rd) begin
					$error("read_value: expected %0h, got %0h", oldest.rd, read_value);
					mismatches++;
				end
				if (count_now !== oldest.cnt) begin
					$error("count_now: expected %0d, got %0d", oldest.cnt, count_now);
					mismatches++;
				end
				if (status !== oldest.st) begin
					$error("status: expected %0d, got %0d", oldest.st, status);
					mismatches++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			model_out = apply_request(op, index, value, length);
			exp_ring[exp_tail % RING_DEPTH] = row_pinned ? row_result : model_out;
			exp_tail++;
		end
	end

	task automatic add_row(input logic [3:0] o, input logic [5:0] i, input logic [31:0] v,
			input logic [6:0] l, input logic pin, input logic [31:0] rd,
			input logic [6:0] cnt, input logic [1:0] st);
		list_row_t row;
		row.op = o;
		row.idx = i;
		row.val = v;
		row.len = l;
		row.pinned = pin;
		row.res.rd = rd;
		row.res.cnt = cnt;
		row.res.st = st;
		directed_rows[row_count] = row;
		row_count++;
	endtask

	// Present one word at the falling edge and hold it until it is taken.
	task automatic send_word(input list_row_t row);
		@(negedge clk);
		start <= 1'b1;
		op <= row.op;
		index <= row.idx;
		value <= row.val;
		length <= row.len;
		row_pinned <= row.pinned;
		row_result <= row.res;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for a number of cycles, with junk on the request fields.
	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start <= 1'b0;
			op <= 4'($urandom);
			index <= 6'($urandom);
			value <= $urandom;
			length <= 7'($urandom);
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Build a random request; the mode leans toward growing, shrinking or a mix.
	function automatic list_row_t make_request(input int mode);
		list_row_t row;
		int r;
		int hi;
		row = '0;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			row.op = 4'($urandom_range(0, 15));
			row.idx = 6'($urandom);
			row.len = 7'($urandom);
			row.val = $urandom;
			return row;
		end
		r = $urandom_range(0, 99);
		case (mode)
			0: begin
				if (r < 15) row.op = ilie_pkg::OP_READ;
				else if (r < 25) row.op = ilie_pkg::OP_WRITE;
				else if (r < 50) row.op = ilie_pkg::OP_INSERT;
				else if (r < 55) row.op = ilie_pkg::OP_ERASE;
				else if (r < 95) row.op = ilie_pkg::OP_PUSH;
				else row.op = ilie_pkg::OP_RESIZE;
			end
			1: begin
				if (r < 15) row.op = ilie_pkg::OP_READ;
				else if (r < 25) row.op = ilie_pkg::OP_WRITE;
				else if (r < 30) row.op = ilie_pkg::OP_INSERT;
				else if (r < 60) row.op = ilie_pkg::OP_ERASE;
				else if (r < 98) row.op = ilie_pkg::OP_POP;
				else row.op = ilie_pkg::OP_CLEAR;
			end
			default: begin
				if (r < 18) row.op = ilie_pkg::OP_READ;
				else if (r < 33) row.op = ilie_pkg::OP_WRITE;
				else if (r < 48) row.op = ilie_pkg::OP_INSERT;
				else if (r < 63) row.op = ilie_pkg::OP_ERASE;
				else if (r < 75) row.op = ilie_pkg::OP_PUSH;
				else if (r < 85) row.op = ilie_pkg::OP_POP;
				else if (r < 88) row.op = ilie_pkg::OP_CLEAR;
				else if (r < 94) row.op = ilie_pkg::OP_RESIZE;
				else row.op = ilie_pkg::OP_ASSIGN;
			end
		endcase
		// Insert may target the slot just past the last entry.
		hi = (row.op == ilie_pkg::OP_INSERT) ? list_len : list_len - 1;
		if (hi > LIST_CAP - 1) hi = LIST_CAP - 1;
		if (hi >= 0 && $urandom_range(0, 99) < 85) row.idx = 6'($urandom_range(0, hi));
		else row.idx = 6'($urandom_range(0, 63));
		if ($urandom_range(0, 9) != 0) row.len = 7'($urandom_range(0, LIST_CAP));
		else row.len = 7'($urandom_range(LIST_CAP + 1, 127));
		case ($urandom_range(0, 19))
			0: row.val = 32'h8000_0000;
			1: row.val = 32'h7fff_ffff;
			2: row.val = 32'hffff_ffff;
			3: row.val = 32'h0000_0000;
			default: row.val = $urandom;
		endcase
		return row;
	endfunction

	initial begin
		int n;
		int mode;
		int phase_left;
		bit burst;
		arst_n = 1'b0;
		start = 1'b0;
		op = ilie_pkg::OP_READ;
		index = '0;
		value = '0;
		length = '0;
		row_pinned = 1'b0;
		row_result = '0;
		mismatches = 0;
		exp_head = 0;
		exp_tail = 0;
		row_count = 0;
		list_len = 0;
		for (n = 0; n < LIST_CAP; n++) list_mem[n] = '0;
		mode = 2;
		phase_left = 0;
		burst = 1'b0;

		// Errors on an empty list, then the extremes of the data field.
		add_row(ilie_pkg::OP_READ, 6'd0, 32'h0, 7'd0, 1'b1, 32'h0, 7'd0, ilie_pkg::ST_RANGE);
		add_row(ilie_pkg::OP_POP, 6'd0, 32'h0, 7'd0, 1'b1, 32'h0, 7'd0, ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_ERASE, 6'd0, 32'h0, 7'd0, 1'b1, 32'h0, 7'd0, ilie_pkg::ST_RANGE);
		add_row(ilie_pkg::OP_INSERT, 6'd1, 32'h1, 7'd0, 1'b1, 32'h0, 7'd0,
			ilie_pkg::ST_RANGE);
		add_row(ilie_pkg::OP_PUSH, 6'd0, 32'h7fff_ffff, 7'd0, 1'b1, 32'h0, 7'd1,
			ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_PUSH, 6'd0, 32'h8000_0000, 7'd0, 1'b1, 32'h0, 7'd2,
			ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_READ, 6'd0, 32'h0, 7'd0, 1'b1, 32'h7fff_ffff, 7'd2,
			ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_READ, 6'd1, 32'h0, 7'd0, 1'b1, 32'h8000_0000, 7'd2,
			ilie_pkg::ST_OK);
		// Shifting inserts and erases, checked against the model.
		add_row(ilie_pkg::OP_INSERT, 6'd1, 32'hffff_ffff, 7'd0, 1'b0, 32'h0, 7'd0,
			ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_INSERT, 6'd3, 32'h1, 7'd0, 1'b0, 32'h0, 7'd0, ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_WRITE, 6'd0, 32'hdead_beef, 7'd0, 1'b0, 32'h0, 7'd0,
			ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_ERASE, 6'd1, 32'h0, 7'd0, 1'b0, 32'h0, 7'd0, ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_READ, 6'd1, 32'h0, 7'd0, 1'b0, 32'h0, 7'd0, ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_WRITE, 6'd63, 32'h5, 7'd0, 1'b1, 32'h0, 7'd3, ilie_pkg::ST_RANGE);
		// Fill to capacity and probe the full list.
		add_row(ilie_pkg::OP_ASSIGN, 6'd0, 32'h5555_5555, 7'd64, 1'b1, 32'h0, 7'd64,
			ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_PUSH, 6'd0, 32'h9, 7'd0, 1'b1, 32'h0, 7'd64, ilie_pkg::ST_FULL);
		add_row(ilie_pkg::OP_INSERT, 6'd63, 32'h9, 7'd0, 1'b1, 32'h0, 7'd64,
			ilie_pkg::ST_FULL);
		add_row(ilie_pkg::OP_READ, 6'd63, 32'h0, 7'd0, 1'b1, 32'h5555_5555, 7'd64,
			ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_RESIZE, 6'd0, 32'h9, 7'd65, 1'b1, 32'h0, 7'd64,
			ilie_pkg::ST_FULL);
		add_row(ilie_pkg::OP_ASSIGN, 6'd0, 32'h9, 7'd127, 1'b1, 32'h0, 7'd64,
			ilie_pkg::ST_FULL);
		// Truncating and growing resize, unknown code, clear, empty assign.
		add_row(ilie_pkg::OP_RESIZE, 6'd0, 32'h9, 7'd10, 1'b1, 32'h0, 7'd10, ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_RESIZE, 6'd0, 32'haaaa_aaaa, 7'd20, 1'b0, 32'h0, 7'd0,
			ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_READ, 6'd15, 32'h0, 7'd0, 1'b0, 32'h0, 7'd0, ilie_pkg::ST_OK);
		add_row(OP_UNKNOWN, 6'd3, 32'h7, 7'd5, 1'b1, 32'h0, 7'd20, ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_CLEAR, 6'd0, 32'h0, 7'd0, 1'b1, 32'h0, 7'd0, ilie_pkg::ST_OK);
		add_row(ilie_pkg::OP_ASSIGN, 6'd0, 32'h3, 7'd0, 1'b1, 32'h0, 7'd0, ilie_pkg::ST_OK);

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		for (n = 0; n < row_count; n++) begin
			send_word(directed_rows[n]);
			idle_for(pick_gap());
		end

		// Random phases, some of them back to back with no idle cycles.
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (phase_left == 0) begin
				mode = $urandom_range(0, 2);
				phase_left = $urandom_range(60, 160);
				burst = ($urandom_range(0, 3) == 0);
			end
			phase_left--;
			send_word(make_request(mode));
			if (!burst) idle_for(pick_gap());
		end

		@(negedge clk);
		start <= 1'b0;
		row_pinned <= 1'b0;
		while (exp_head != exp_tail) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("indexed_list_insert_erase: match");
		end else begin
			$display("indexed_list_insert_erase: mismatch");
		end
		$finish;
	end

endmodule
